// File: rtl/core/rvs_pkg.sv
// ----------------------------------------------------------------------------
// rvs_pkg
// shared types and codes of the rv32i subset execute core
// ----------------------------------------------------------------------------
package rvs_pkg;

  localparam logic [6:0] OPC_R     = 7'h33;
  localparam logic [6:0] OPC_JALR  = 7'h67;
  localparam logic [6:0] OPC_LOAD  = 7'h03;
  localparam logic [6:0] OPC_IMM   = 7'h13;
  localparam logic [6:0] OPC_STORE = 7'h23;
  localparam logic [6:0] OPC_BR    = 7'h63;
  localparam logic [6:0] OPC_JAL   = 7'h6F;
  localparam logic [6:0] OPC_LUI   = 7'h37;
  localparam logic [6:0] OPC_AUIPC = 7'h17;
  localparam logic [6:0] F7_ALT    = 7'h20;

  localparam logic [31:0] RST_BASE    = 32'h1000_0000;
  localparam logic [31:0] RST_CONSOLE = 32'h2000_0000;

  localparam logic [0:0] REG_BASE    = 1'b0;
  localparam logic [0:0] REG_CONSOLE = 1'b1;

  // operation classes
  localparam logic [3:0] OP_R     = 4'd0;
  localparam logic [3:0] OP_IMM   = 4'd1;
  localparam logic [3:0] OP_JALR  = 4'd2;
  localparam logic [3:0] OP_LOAD  = 4'd3;
  localparam logic [3:0] OP_STORE = 4'd4;
  localparam logic [3:0] OP_BR    = 4'd5;
  localparam logic [3:0] OP_JAL   = 4'd6;
  localparam logic [3:0] OP_LUI   = 4'd7;
  localparam logic [3:0] OP_AUIPC = 4'd8;
  localparam logic [3:0] OP_ILL   = 4'd9;
  localparam logic [3:0] OP_PRE   = 4'd10;

  typedef struct packed {
    logic [3:0]  op;
    logic [2:0]  f3;
    logic        alt;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    logic [31:0] cval;
    logic [15:0] pre_off;
    logic [7:0]  pre_byte;
  } dec_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] console;
  } cfg_t;

endpackage

// File: rtl/core/rvs_front.sv
// ----------------------------------------------------------------------------
// rvs_front
// accepts input transactions and decodes them into operation records
// ----------------------------------------------------------------------------
module rvs_front (
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [87:0]       s_tdata,
  input  logic              s_tuser,
  input  logic              q_full,
  input  logic              clr_done,
  output logic              q_push,
  output rvs_pkg::dec_t     q_data
);

  function automatic logic [31:0] quarter(input logic [31:0] v);
    logic [31:0] mag;
    mag = (~v + 32'd1) >> 2;
    if (v[31]) return ~mag + 32'd1;
    return v >> 2;
  endfunction

  logic [31:0] ins;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_u;

  assign ins   = s_tdata[31:0];
  assign imm_i = {{20{ins[31]}}, ins[31:20]};
  assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  assign imm_u = {ins[31:12], 12'b0};

  assign s_tready = !q_full && clr_done;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    q_data          = '0;
    q_data.f3       = ins[14:12];
    q_data.alt      = (ins[31:25] == rvs_pkg::F7_ALT);
    q_data.rd       = ins[11:7];
    q_data.rs1      = ins[19:15];
    q_data.rs2      = ins[24:20];
    q_data.cval     = s_tdata[63:32];
    q_data.pre_off  = s_tdata[79:64];
    q_data.pre_byte = s_tdata[87:80];
    q_data.imm      = imm_i;
    if (s_tuser) begin
      q_data.op = rvs_pkg::OP_PRE;
    end else begin
      case (ins[6:0])
        rvs_pkg::OPC_R:     q_data.op = rvs_pkg::OP_R;
        rvs_pkg::OPC_IMM:   q_data.op = rvs_pkg::OP_IMM;
        rvs_pkg::OPC_JALR:  q_data.op = rvs_pkg::OP_JALR;
        rvs_pkg::OPC_LOAD:  q_data.op = rvs_pkg::OP_LOAD;
        rvs_pkg::OPC_STORE: begin
          q_data.op  = rvs_pkg::OP_STORE;
          q_data.imm = imm_s;
        end
        rvs_pkg::OPC_BR: begin
          q_data.op  = rvs_pkg::OP_BR;
          q_data.imm = quarter(imm_b);
        end
        rvs_pkg::OPC_JAL: begin
          q_data.op  = rvs_pkg::OP_JAL;
          q_data.imm = quarter(imm_j);
        end
        rvs_pkg::OPC_LUI: begin
          q_data.op  = rvs_pkg::OP_LUI;
          q_data.imm = imm_u;
        end
        rvs_pkg::OPC_AUIPC: begin
          q_data.op  = rvs_pkg::OP_AUIPC;
          q_data.imm = imm_u;
        end
        default: q_data.op = rvs_pkg::OP_ILL;
      endcase
    end
  end

endmodule

// File: rtl/core/rvs_fifo.sv
// ----------------------------------------------------------------------------
// rvs_fifo
// two-entry queue of decoded operations between front and back
// ----------------------------------------------------------------------------
module rvs_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rvs_pkg::dec_t     wdata,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output rvs_pkg::dec_t     head
);

  rvs_pkg::dec_t entry [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = entry[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        entry[wp] <= wdata;
        wp        <= ~wp;
      end
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/core/rvs_urem.sv
// ----------------------------------------------------------------------------
// rvs_urem
// remainder of a 32-bit value by the store size, by reciprocal multiplication
// ----------------------------------------------------------------------------
module rvs_urem #(
  parameter int DATA_BYTES = 65536
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [31:0]                   x,
  output logic                          done,
  output logic [$clog2(DATA_BYTES)-1:0] rem
);

  localparam int AW = $clog2(DATA_BYTES);
  localparam logic [63:0] RECIP_W = (64'd1 << 32) / 64'(DATA_BYTES);
  localparam logic [31:0] RECIP   = RECIP_W[31:0];
  localparam logic [31:0] DIV     = 32'(DATA_BYTES);

  logic [31:0] xr;
  logic [63:0] prod;
  logic [31:0] r1;
  logic [31:0] r2;
  logic [1:0]  stage;

  // quotient estimate is at most one short, one subtract corrects it
  assign r2 = (r1 >= DIV) ? r1 - DIV : r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= 2'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (stage)
        2'd0: begin
          if (start) stage <= 2'd1;
        end
        2'd3: begin
          stage <= 2'd0;
          done  <= 1'b1;
        end
        default: stage <= stage + 2'd1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) xr <= x;
    prod <= {32'd0, xr} * {32'd0, RECIP};
    r1   <= xr - prod[63:32] * DIV;
    if (stage == 2'd3) rem <= r2[AW-1:0];
  end

endmodule

// File: rtl/core/rvs_back.sv
// ----------------------------------------------------------------------------
// rvs_back
// executes decoded operations: register file, pc, byte data store, result
// ----------------------------------------------------------------------------
module rvs_back #(
  parameter int DATA_BYTES = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  rvs_pkg::cfg_t     cfg,
  input  logic              q_valid,
  input  rvs_pkg::dec_t     q_head,
  output logic              q_pop,
  output logic              clr_done,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [87:0]       m_tdata
);

  localparam int AW = $clog2(DATA_BYTES);
  localparam logic [AW-1:0] LAST = AW'(DATA_BYTES - 1);

  localparam logic [2:0] ST_CLR = 3'd0;
  localparam logic [2:0] ST_RUN = 3'd1;
  localparam logic [2:0] ST_MOD = 3'd2;
  localparam logic [2:0] ST_LD  = 3'd3;
  localparam logic [2:0] ST_ST  = 3'd4;
  localparam logic [2:0] ST_PRE = 3'd5;
  localparam logic [2:0] ST_OUT = 3'd6;

  logic [2:0]    state;
  logic [31:0]   pc;
  logic [31:0]   rf [32];
  logic [7:0]    mem [DATA_BYTES];
  logic [7:0]    rdata;

  logic [3:0]    mop;
  logic [4:0]    mrd;
  logic [31:0]   mval;
  logic [7:0]    mbyte;
  logic [AW-1:0] idx;
  logic [2:0]    cnt;

  logic [31:0]   o_pc;
  logic          o_wr;
  logic [4:0]    o_rd;
  logic [31:0]   o_val;
  logic          o_cov;
  logic [7:0]    o_ch;
  logic          o_ciu;
  logic          o_ill;
  logic          o_load;

  logic          slot;
  logic [31:0]   a;
  logic [31:0]   b;
  logic [31:0]   addr;
  logic [4:0]    sh;
  logic [31:0]   opb;
  logic [31:0]   res;
  logic [31:0]   nxt;
  logic          wr;
  logic          take;
  logic          cons;
  logic          go_mem;

  logic          u_start;
  logic [31:0]   u_x;
  logic          u_done;
  logic [AW-1:0] u_rem;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [AW-1:0] idx_inc;

  rvs_urem #(.DATA_BYTES(DATA_BYTES)) u_rem_unit (
    .clk(clk), .rst(rst), .start(u_start), .x(u_x), .done(u_done), .rem(u_rem)
  );

  assign slot     = !m_tvalid || m_tready;
  assign clr_done = (state != ST_CLR);
  assign q_pop    = (state == ST_RUN) && q_valid && slot;
  assign o_load   = (q_pop && !go_mem) || ((state == ST_OUT) && slot);
  assign idx_inc  = (idx == LAST) ? '0 : idx + AW'(1);
  assign m_tdata  = {7'd0, o_ill, o_ciu, o_ch, o_cov, o_val, o_rd, o_wr, o_pc};

  assign a    = rf[q_head.rs1];
  assign b    = rf[q_head.rs2];
  assign addr = a + q_head.imm;
  assign cons = (addr == cfg.console);
  assign opb  = (q_head.op == rvs_pkg::OP_R) ? b : q_head.imm;
  assign sh   = (q_head.op == rvs_pkg::OP_R) ? b[4:0] : q_head.rs2;

  always_comb begin
    res  = '0;
    nxt  = pc + 32'd1;
    wr   = 1'b0;
    take = 1'b0;
    case (q_head.op)
      rvs_pkg::OP_R, rvs_pkg::OP_IMM: begin
        wr = 1'b1;
        case (q_head.f3)
          3'd0: res = (q_head.op == rvs_pkg::OP_R && q_head.alt) ? a - b : a + opb;
          3'd1: res = a << sh;
          3'd2: res = {31'd0, $signed(a) < $signed(opb)};
          3'd3: res = {31'd0, a < opb};
          3'd4: res = a ^ opb;
          3'd5: res = q_head.alt ? 32'($signed(a) >>> sh) : a >> sh;
          3'd6: res = a | opb;
          default: res = a & opb;
        endcase
      end
      rvs_pkg::OP_JALR: begin
        wr  = 1'b1;
        res = (pc << 2) + 32'd4;
        nxt = addr >> 2;
      end
      rvs_pkg::OP_LOAD: begin
        wr  = 1'b1;
        res = q_head.cval;
      end
      rvs_pkg::OP_BR: begin
        case (q_head.f3)
          3'd0: take = (a == b);
          3'd1: take = (a != b);
          3'd4: take = $signed(a) < $signed(b);
          3'd5: take = !($signed(a) < $signed(b));
          3'd6: take = a < b;
          3'd7: take = a >= b;
          default: take = 1'b0;
        endcase
        if (take) nxt = pc + q_head.imm;
      end
      rvs_pkg::OP_JAL: begin
        wr  = 1'b1;
        res = (pc << 2) + 32'd4;
        nxt = pc + q_head.imm;
      end
      rvs_pkg::OP_LUI: begin
        wr  = 1'b1;
        res = q_head.imm;
      end
      rvs_pkg::OP_AUIPC: begin
        wr  = 1'b1;
        res = (pc << 2) + q_head.imm;
      end
      default: begin
        wr = 1'b0;
      end
    endcase
    if (q_head.rd == 5'd0) res = '0;
  end

  always_comb begin
    go_mem  = (q_head.op == rvs_pkg::OP_PRE) ||
              ((q_head.op == rvs_pkg::OP_LOAD || q_head.op == rvs_pkg::OP_STORE) && !cons);
    u_start = q_pop && go_mem;
    u_x     = (q_head.op == rvs_pkg::OP_PRE) ? {16'd0, q_head.pre_off} : addr - cfg.base;
    we      = 1'b0;
    waddr   = idx;
    wdata   = '0;
    re      = 1'b0;
    case (state)
      ST_CLR: we = 1'b1;
      ST_PRE: begin
        we    = 1'b1;
        wdata = mbyte;
      end
      ST_ST: begin
        we    = 1'b1;
        wdata = mval[8*cnt[1:0] +: 8];
      end
      ST_LD: re = (cnt != 3'd4);
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      pc       <= '0;
      idx      <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < 32; i++) rf[i] <= '0;
    end else begin
      if (o_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_CLR: begin
          idx <= idx_inc;
          if (idx == LAST) state <= ST_RUN;
        end
        ST_RUN: begin
          if (q_pop) begin
            mop   <= q_head.op;
            mrd   <= q_head.rd;
            mval  <= b;
            mbyte <= q_head.pre_byte;
            if (go_mem) begin
              state <= ST_MOD;
            end else begin
              o_cov <= (q_head.op == rvs_pkg::OP_STORE);
              o_ch  <= (q_head.op == rvs_pkg::OP_STORE) ? b[7:0] : 8'd0;
              o_ciu <= (q_head.op == rvs_pkg::OP_LOAD);
              o_ill <= (q_head.op == rvs_pkg::OP_ILL);
              o_wr  <= wr;
              o_rd  <= wr ? q_head.rd : 5'd0;
              o_val <= wr ? res : 32'd0;
              o_pc  <= (q_head.op == rvs_pkg::OP_ILL) ? pc << 2 : nxt << 2;
              if (q_head.op != rvs_pkg::OP_ILL) begin
                pc <= nxt;
                if (wr && q_head.rd != 5'd0) rf[q_head.rd] <= res;
              end
            end
          end
        end
        ST_MOD: begin
          if (u_done) begin
            idx <= u_rem;
            cnt <= 3'd0;
            case (mop)
              rvs_pkg::OP_LOAD:  state <= ST_LD;
              rvs_pkg::OP_STORE: state <= ST_ST;
              default:           state <= ST_PRE;
            endcase
          end
        end
        ST_PRE: state <= ST_OUT;
        ST_ST: begin
          idx <= idx_inc;
          cnt <= cnt + 3'd1;
          if (cnt == 3'd3) state <= ST_OUT;
        end
        ST_LD: begin
          idx <= idx_inc;
          cnt <= cnt + 3'd1;
          if (cnt != 3'd0) mval[8*(3'(cnt - 3'd1)) +: 8] <= rdata;
          if (cnt == 3'd4) state <= ST_OUT;
        end
        ST_OUT: begin
          if (slot) begin
            state <= ST_RUN;
            o_cov <= 1'b0;
            o_ch  <= '0;
            o_ciu <= 1'b0;
            o_ill <= 1'b0;
            o_wr  <= (mop == rvs_pkg::OP_LOAD);
            o_rd  <= (mop == rvs_pkg::OP_LOAD) ? mrd : 5'd0;
            o_val <= (mop == rvs_pkg::OP_LOAD && mrd != 5'd0) ? mval : 32'd0;
            o_pc  <= (mop == rvs_pkg::OP_PRE) ? pc << 2 : (pc + 32'd1) << 2;
            if (mop != rvs_pkg::OP_PRE) pc <= pc + 32'd1;
            if (mop == rvs_pkg::OP_LOAD && mrd != 5'd0) rf[mrd] <= mval;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

endmodule

// File: rtl/core/rv32i_subset_execute_step_core.sv
// ----------------------------------------------------------------------------
// rv32i_subset_execute_step_core
// rv32i subset execute step with decoupled decode and execute
//
// channel  direction  handshake          payload
// s_       in         tvalid/tready      tdata: instr, console value, preload
// m_       out        tvalid/tready      tdata: one result per transaction
// apb      in         psel/penable       data_base at 0x0, console_address 0x4
//
// alu, branch, jump, lui, auipc, console load/store: back to back while the output is not stalled
// data store: store, load and preload first pass through the remainder unit, then
// move one byte a cycle on the single store port
// after reset a clearing pass over all DATA_BYTES bytes holds s_tready low
// a two-entry queue and the output register let each side stall alone
// ----------------------------------------------------------------------------
module rv32i_subset_execute_step_core #(
  parameter int DATA_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // instr_word, console_value, preload_offset, preload_byte
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // next_pc, reg_written, dest_reg, dest_value,
                                 // console_out_valid, console_char, console_in_used,
                                 // illegal_instruction
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rvs_pkg::cfg_t cfg;
  rvs_pkg::dec_t f_data;
  rvs_pkg::dec_t q_head;
  logic          q_full;
  logic          q_push;
  logic          q_valid;
  logic          q_pop;
  logic          clr_done;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == rvs_pkg::REG_CONSOLE) ? cfg.console : cfg.base;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base    <= rvs_pkg::RST_BASE;
      cfg.console <= rvs_pkg::RST_CONSOLE;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == rvs_pkg::REG_CONSOLE) cfg.console <= pwdata;
      else cfg.base <= pwdata;
    end
  end

  rvs_front u_front (
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .q_full(q_full), .clr_done(clr_done), .q_push(q_push), .q_data(f_data)
  );

  rvs_fifo u_fifo (
    .clk(clk), .rst(rst), .push(q_push), .wdata(f_data), .full(q_full),
    .pop(q_pop), .valid(q_valid), .head(q_head)
  );

  rvs_back #(.DATA_BYTES(DATA_BYTES)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_head(q_head),
    .q_pop(q_pop), .clr_done(clr_done), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

endmodule

// File: rtl/core/rvs_checker.sv
// ----------------------------------------------------------------------------
// rvs_checker
// port-level checks of the execute core, bound to the top level
// ----------------------------------------------------------------------------
module rvs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_clear: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input taken during clearing pass");

  a_ill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[80] |-> !m_tdata[32] && !m_tdata[70] && !m_tdata[79])
    else $error("illegal instruction with side effects");

  a_nowr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[32] |-> m_tdata[69:33] == 37'd0)
    else $error("destination fields set without a register write");

  a_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[70] |-> m_tdata[78:71] == 8'd0)
    else $error("console char without console output");

endmodule

bind rv32i_subset_execute_step_core rvs_checker u_rvs_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata)
);
